// ----- rtl/keyframe_piecewise_lerp_unit_macros.svh -----
`ifndef KEYFRAME_PIECEWISE_LERP_UNIT_MACROS_SVH
`define KEYFRAME_PIECEWISE_LERP_UNIT_MACROS_SVH

// Checks sampled on the rising clock edge, switched off while reset is high.
`define KLERP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define KLERP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/klerp_pkg.sv -----
`timescale 1ns / 1ps
package klerp_pkg;

   localparam int OP_BITS       = 2;
   localparam int DUR_BITS      = 16;
   localparam int TIME_BITS     = 32;
   localparam int COUNT_BITS    = 3;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_IDX_BITS  = 2;

   typedef logic [OP_BITS-1:0] op_code_type;

   localparam op_code_type OP_QUERY    = 2'd0;
   localparam op_code_type OP_KEY      = 2'd1;
   localparam op_code_type OP_DURATION = 2'd2;

   typedef logic [REG_IDX_BITS-1:0] reg_idx_type;

   localparam reg_idx_type REG_START_TIME    = 2'd0;
   localparam reg_idx_type REG_SEGMENT_COUNT = 2'd1;
   localparam reg_idx_type REG_INTERPOLATE   = 2'd2;

endpackage

// ----- rtl/klerp_req_if.sv -----
`timescale 1ns / 1ps
interface klerp_req_if #(
   parameter int SLOT_BITS  = 3,
   parameter int VALUE_BITS = 16
);
   import klerp_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [OP_BITS-1:0]           op;
   logic [SLOT_BITS-1:0]         slot;
   logic signed [VALUE_BITS-1:0] key_value;
   logic [DUR_BITS-1:0]          duration;
   logic [TIME_BITS-1:0]         query_time;

   modport source (output valid, op, slot, key_value, duration, query_time, input ready);
   modport sink (input valid, op, slot, key_value, duration, query_time, output ready);

endinterface

// ----- rtl/klerp_rsp_if.sv -----
`timescale 1ns / 1ps
interface klerp_rsp_if #(
   parameter int SLOT_BITS  = 3,
   parameter int VALUE_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] value;
   logic [SLOT_BITS-1:0]         segment;
   logic                         past_end;

   modport source (output valid, value, segment, past_end, input ready);
   modport sink (input valid, value, segment, past_end, output ready);

endinterface

// ----- rtl/keyframe_piecewise_lerp_unit.sv -----
// A write beat leaves the input ready; a query holds the input until its result loads.
// A query runs the setup step and goes straight to emit when early or with no segments.
// Else it walks past segments, one microcode step each, loads key a and emits in hold mode
// or past the end; when interpolating it goes on through diff, multiply, divide and sum.
// The serial divider produces one quotient bit per cycle.
// Synchronous reset clears keys, durations and registers at once; no clearing pass.
`timescale 1ns / 1ps
`include "keyframe_piecewise_lerp_unit_macros.svh"
module keyframe_piecewise_lerp_unit #(
   parameter int MAX_SEGMENTS = 5,
   parameter int VALUE_BITS   = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   klerp_req_if.sink                             req_ch,
   klerp_rsp_if.source                           rsp_ch,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [klerp_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [klerp_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [klerp_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                  csr_pready
);
   import klerp_pkg::*;

   localparam int IDX_BITS     = $clog2(MAX_SEGMENTS + 1);
   localparam int DUR_IDX_BITS = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CNT_BITS     = $clog2(VALUE_BITS + 1);
   localparam int PROD_BITS    = VALUE_BITS + DUR_BITS;

   typedef enum logic [3:0] {
      ACT_ACCEPT, ACT_SETUP, ACT_WALK, ACT_LOAD_A, ACT_DIFF,
      ACT_MUL, ACT_DIV, ACT_SUM, ACT_EMIT
   } act_type;

   typedef enum logic [2:0] {
      COND_ALWAYS, COND_NEVER, COND_NO_QUERY, COND_EARLY,
      COND_WALK, COND_NO_LERP, COND_DIV_MORE
   } cond_type;

   typedef logic [3:0] step_type;

   localparam step_type STEP_WAIT   = 4'd0;
   localparam step_type STEP_SETUP  = 4'd1;
   localparam step_type STEP_WALK   = 4'd2;
   localparam step_type STEP_LOAD_A = 4'd3;
   localparam step_type STEP_DIFF   = 4'd4;
   localparam step_type STEP_MUL    = 4'd5;
   localparam step_type STEP_DIV    = 4'd6;
   localparam step_type STEP_SUM    = 4'd7;
   localparam step_type STEP_EMIT   = 4'd8;

   typedef struct packed {
      act_type  act;
      cond_type cond;
      step_type target;
   } uword_type;

   // Control store: the next step is target when the condition holds, else the one after.
   function automatic uword_type ucode_rom(input step_type step);
      uword_type w;
      unique case (step)
         STEP_WAIT:   w = '{act: ACT_ACCEPT, cond: COND_NO_QUERY, target: STEP_WAIT};
         STEP_SETUP:  w = '{act: ACT_SETUP,  cond: COND_EARLY,    target: STEP_EMIT};
         STEP_WALK:   w = '{act: ACT_WALK,   cond: COND_WALK,     target: STEP_WALK};
         STEP_LOAD_A: w = '{act: ACT_LOAD_A, cond: COND_NO_LERP,  target: STEP_EMIT};
         STEP_DIFF:   w = '{act: ACT_DIFF,   cond: COND_NEVER,    target: STEP_WAIT};
         STEP_MUL:    w = '{act: ACT_MUL,    cond: COND_NEVER,    target: STEP_WAIT};
         STEP_DIV:    w = '{act: ACT_DIV,    cond: COND_DIV_MORE, target: STEP_DIV};
         STEP_SUM:    w = '{act: ACT_SUM,    cond: COND_NEVER,    target: STEP_WAIT};
         STEP_EMIT:   w = '{act: ACT_EMIT,   cond: COND_ALWAYS,   target: STEP_WAIT};
         default:     w = '{act: ACT_ACCEPT, cond: COND_ALWAYS,   target: STEP_WAIT};
      endcase
      return w;
   endfunction

   // Control state
   step_type               pc_ff, pc_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [TIME_BITS-1:0]   start_ff, start_in;
   logic [COUNT_BITS-1:0]  seg_count_ff, seg_count_in;
   logic                   interp_ff, interp_in;
   logic [VALUE_BITS-1:0]  keys_ff [MAX_SEGMENTS+1];
   logic [VALUE_BITS-1:0]  keys_in [MAX_SEGMENTS+1];
   logic [DUR_BITS-1:0]    durs_ff [MAX_SEGMENTS];
   logic [DUR_BITS-1:0]    durs_in [MAX_SEGMENTS];

   // Datapath
   logic [TIME_BITS-1:0]   t_ff, t_in;
   logic [TIME_BITS-1:0]   acc_ff, acc_in;
   logic [IDX_BITS-1:0]    idx_ff, idx_in;
   logic [IDX_BITS-1:0]    cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0]  a_ff, a_in;
   logic [VALUE_BITS:0]    diff_ff, diff_in;
   logic [DUR_BITS-1:0]    off_ff, off_in;
   logic [DUR_BITS-1:0]    rem_ff, rem_in;
   logic [VALUE_BITS-1:0]  quo_ff, quo_in;
   logic                   neg_ff, neg_in;
   logic [CNT_BITS-1:0]    div_cnt_ff, div_cnt_in;
   logic [VALUE_BITS-1:0]  res_value_ff, res_value_in;
   logic [IDX_BITS-1:0]    res_seg_ff, res_seg_in;
   logic                   res_past_ff, res_past_in;
   logic [VALUE_BITS-1:0]  rsp_value_ff, rsp_value_in;
   logic [IDX_BITS-1:0]    rsp_seg_ff, rsp_seg_in;
   logic                   rsp_past_ff, rsp_past_in;

   uword_type              uw;
   logic                   cond_true;
   logic                   stall;
   logic                   out_busy;
   logic                   req_fire;
   logic                   csr_write;
   reg_idx_type            csr_idx;
   logic [IDX_BITS-1:0]    cnt_eff;
   logic [IDX_BITS-1:0]    key_sel;
   logic [VALUE_BITS-1:0]  key_rd;
   logic [DUR_BITS-1:0]    dur_rd;
   logic [TIME_BITS:0]     acc_sum;
   logic                   early;
   logic                   walk_go;
   logic                   at_end;
   logic [VALUE_BITS:0]    diff_abs;
   logic [VALUE_BITS-1:0]  diff_mag;
   logic [PROD_BITS-1:0]   prod;
   logic [DUR_BITS:0]      trial;
   logic                   trial_ge;
   logic [VALUE_BITS:0]    quo_signed;
   logic [VALUE_BITS:0]    lerp_sum;

   assign uw         = ucode_rom(pc_ff);
   assign out_busy   = rsp_valid_ff && !rsp_ch.ready;
   assign stall      = (uw.act == ACT_EMIT) && out_busy;
   assign req_fire   = req_ch.valid && req_ch.ready;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[REG_IDX_BITS+1:2];
   assign csr_pready = 1'b1;

   assign req_ch.ready    = (pc_ff == STEP_WAIT);
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.value    = rsp_value_ff;
   assign rsp_ch.segment  = rsp_seg_ff;
   assign rsp_ch.past_end = rsp_past_ff;

   assign cnt_eff = (32'(seg_count_ff) > MAX_SEGMENTS) ? IDX_BITS'(MAX_SEGMENTS)
                                                       : IDX_BITS'(seg_count_ff);

   always_comb begin
      case (uw.act)
         ACT_LOAD_A: key_sel = idx_ff;
         ACT_DIFF:   key_sel = IDX_BITS'(idx_ff + 1'b1);
         default:    key_sel = '0;
      endcase
   end

   assign key_rd  = keys_ff[key_sel];
   assign dur_rd  = (idx_ff < IDX_BITS'(MAX_SEGMENTS)) ? durs_ff[idx_ff[DUR_IDX_BITS-1:0]]
                                                       : '0;
   assign acc_sum = (TIME_BITS+1)'(acc_ff) + (TIME_BITS+1)'(dur_rd);
   assign early   = (t_ff <= start_ff) || (cnt_eff == '0);
   assign at_end  = (idx_ff == cnt_ff);
   assign walk_go = !at_end && ({1'b0, t_ff} > acc_sum);

   // |b - a| always fits the value width, since both keys do.
   assign diff_abs = diff_ff[VALUE_BITS] ? (VALUE_BITS+1)'(-diff_ff) : diff_ff;
   assign diff_mag = diff_abs[VALUE_BITS-1:0];
   assign prod     = PROD_BITS'(diff_mag) * PROD_BITS'(off_ff);

   assign trial    = {rem_ff, quo_ff[VALUE_BITS-1]};
   assign trial_ge = (trial >= {1'b0, dur_rd});

   assign quo_signed = neg_ff ? (VALUE_BITS+1)'(-{1'b0, quo_ff}) : {1'b0, quo_ff};
   assign lerp_sum   = {a_ff[VALUE_BITS-1], a_ff} + quo_signed;

   always_comb begin
      case (uw.cond)
         COND_ALWAYS:   cond_true = 1'b1;
         COND_NEVER:    cond_true = 1'b0;
         COND_NO_QUERY: cond_true = !(req_fire && req_ch.op == OP_QUERY);
         COND_EARLY:    cond_true = early;
         COND_WALK:     cond_true = walk_go;
         COND_NO_LERP:  cond_true = at_end || !interp_ff;
         COND_DIV_MORE: cond_true = (div_cnt_ff != CNT_BITS'(1));
         default:       cond_true = 1'b0;
      endcase
   end

   always_comb begin
      if (stall) begin
         pc_in = pc_ff;
      end else if (cond_true) begin
         pc_in = uw.target;
      end else begin
         pc_in = step_type'(pc_ff + 1'b1);
      end
   end

   always_comb begin
      start_in     = start_ff;
      seg_count_in = seg_count_ff;
      interp_in    = interp_ff;
      if (csr_write) begin
         unique case (csr_idx)
            REG_START_TIME:    start_in     = csr_pwdata[TIME_BITS-1:0];
            REG_SEGMENT_COUNT: seg_count_in = csr_pwdata[COUNT_BITS-1:0];
            REG_INTERPOLATE:   interp_in    = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_START_TIME:    csr_prdata = CSR_DATA_BITS'(start_ff);
         REG_SEGMENT_COUNT: csr_prdata = CSR_DATA_BITS'(seg_count_ff);
         REG_INTERPOLATE:   csr_prdata = CSR_DATA_BITS'(interp_ff);
         default:           csr_prdata = '0;
      endcase
   end

   always_comb begin
      keys_in      = keys_ff;
      durs_in      = durs_ff;
      t_in         = t_ff;
      acc_in       = acc_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      a_in         = a_ff;
      diff_in      = diff_ff;
      off_in       = off_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      neg_in       = neg_ff;
      div_cnt_in   = div_cnt_ff;
      res_value_in = res_value_ff;
      res_seg_in   = res_seg_ff;
      res_past_in  = res_past_ff;
      rsp_value_in = rsp_value_ff;
      rsp_seg_in   = rsp_seg_ff;
      rsp_past_in  = rsp_past_ff;
      rsp_valid_in = out_busy;

      case (uw.act)
         ACT_ACCEPT: begin
            if (req_fire) begin
               unique case (req_ch.op)
                  OP_QUERY: t_in = req_ch.query_time;
                  OP_KEY: begin
                     if (32'(req_ch.slot) <= MAX_SEGMENTS) begin
                        keys_in[req_ch.slot] = req_ch.key_value;
                     end
                  end
                  OP_DURATION: begin
                     if (32'(req_ch.slot) < MAX_SEGMENTS) begin
                        durs_in[req_ch.slot[DUR_IDX_BITS-1:0]] = req_ch.duration;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ACT_SETUP: begin
            acc_in       = start_ff;
            idx_in       = '0;
            cnt_in       = cnt_eff;
            res_value_in = key_rd;
            res_seg_in   = '0;
            res_past_in  = 1'b0;
         end
         ACT_WALK: begin
            // A segment of zero length never holds the time, so it is simply stepped over.
            if (walk_go) begin
               acc_in = acc_sum[TIME_BITS-1:0];
               idx_in = IDX_BITS'(idx_ff + 1'b1);
            end
         end
         ACT_LOAD_A: begin
            a_in         = key_rd;
            res_value_in = key_rd;
            res_seg_in   = idx_ff;
            res_past_in  = at_end;
         end
         ACT_DIFF: begin
            diff_in = {key_rd[VALUE_BITS-1], key_rd} - {a_ff[VALUE_BITS-1], a_ff};
            off_in  = DUR_BITS'(t_ff - acc_ff);
         end
         ACT_MUL: begin
            // The quotient is at most |b - a|, so the upper product bits already
            // sit below the divisor and start as the partial remainder.
            rem_in     = prod[PROD_BITS-1:VALUE_BITS];
            quo_in     = prod[VALUE_BITS-1:0];
            neg_in     = diff_ff[VALUE_BITS];
            div_cnt_in = CNT_BITS'(VALUE_BITS);
         end
         ACT_DIV: begin
            if (trial_ge) begin
               rem_in = DUR_BITS'(trial - {1'b0, dur_rd});
            end else begin
               rem_in = trial[DUR_BITS-1:0];
            end
            quo_in     = {quo_ff[VALUE_BITS-2:0], trial_ge};
            div_cnt_in = CNT_BITS'(div_cnt_ff - 1'b1);
         end
         ACT_SUM: begin
            res_value_in = lerp_sum[VALUE_BITS-1:0];
         end
         ACT_EMIT: begin
            if (!out_busy) begin
               rsp_value_in = res_value_ff;
               rsp_seg_in   = res_seg_ff;
               rsp_past_in  = res_past_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_WAIT;
         rsp_valid_ff <= 1'b0;
         start_ff     <= '0;
         seg_count_ff <= '0;
         interp_ff    <= 1'b1;
         for (int i = 0; i < MAX_SEGMENTS + 1; i++) begin
            keys_ff[i] <= '0;
         end
         for (int i = 0; i < MAX_SEGMENTS; i++) begin
            durs_ff[i] <= '0;
         end
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         start_ff     <= start_in;
         seg_count_ff <= seg_count_in;
         interp_ff    <= interp_in;
         keys_ff      <= keys_in;
         durs_ff      <= durs_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff         <= t_in;
      acc_ff       <= acc_in;
      idx_ff       <= idx_in;
      cnt_ff       <= cnt_in;
      a_ff         <= a_in;
      diff_ff      <= diff_in;
      off_ff       <= off_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      neg_ff       <= neg_in;
      div_cnt_ff   <= div_cnt_in;
      res_value_ff <= res_value_in;
      res_seg_ff   <= res_seg_in;
      res_past_ff  <= res_past_in;
      rsp_value_ff <= rsp_value_in;
      rsp_seg_ff   <= rsp_seg_in;
      rsp_past_ff  <= rsp_past_in;
   end

   `KLERP_ASSERT_NOW(a_div_nonzero, pc_ff == STEP_DIV, dur_rd != '0, "divide by a zero duration")
   `KLERP_ASSERT_NOW(a_idx_bound, (pc_ff != STEP_WAIT) && (pc_ff != STEP_SETUP), idx_ff <= cnt_ff, "segment index past the count")
   `KLERP_ASSERT_NOW(a_quo_bound, pc_ff == STEP_SUM, quo_ff <= diff_mag, "quotient exceeds key difference")
   `KLERP_ASSERT_NOW(a_rsp_source, $rose(rsp_valid_ff), $past(pc_ff) == STEP_EMIT, "result beat not from the emit step")
   `KLERP_ASSERT_NEXT(a_emit_done, (pc_ff == STEP_EMIT) && !out_busy, rsp_valid_ff && (pc_ff == STEP_WAIT), "emit step did not complete")

endmodule

// ----- verif/keyframe_piecewise_lerp_unit_tb.sv -----
`timescale 1ns / 1ps
module keyframe_piecewise_lerp_unit_tb;
   import klerp_pkg::*;

   localparam int SEG_LIMIT     = 5;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_PHASES = 16;
   localparam int PHASE_ITEMS   = 100;

   localparam op_code_type OP_RESERVED = 2'd3;

   typedef struct packed {
      op_code_type        op;
      logic [2:0]         slot;
      logic signed [15:0] key_value;
      logic [15:0]        duration;
      logic [31:0]        query_time;
   } key_beat_type;

   typedef struct packed {
      logic signed [15:0] value;
      logic [2:0]         segment;
      logic               past_end;
   } lerp_result_type;

   class keyframe_checker;
      logic [31:0]        start_time;
      logic [2:0]         seg_count;
      logic               interp;
      logic signed [15:0] keys [0:SEG_LIMIT];
      logic [15:0]        durs [0:SEG_LIMIT-1];
      lerp_result_type    awaited_values [$];
      int                 mismatches;
      int                 n_checked;
      int                 n_queries;
      int                 n_early;
      int                 n_past;
      int                 n_inside;

      function new();
         start_time = '0;
         seg_count  = '0;
         interp     = 1'b1;
         foreach (keys[i]) keys[i] = '0;
         foreach (durs[i]) durs[i] = '0;
         mismatches = 0;
         n_checked  = 0;
         n_queries  = 0;
         n_early    = 0;
         n_past     = 0;
         n_inside   = 0;
      endfunction

      function int outstanding();
         return awaited_values.size();
      endfunction

      function void set_register(reg_idx_type idx, logic [31:0] data);
         case (idx)
            REG_START_TIME:    start_time = data;
            REG_SEGMENT_COUNT: seg_count  = data[2:0];
            REG_INTERPOLATE:   interp     = data[0];
            default: ;
         endcase
      endfunction

      // The walk sums durations in 64 bits so that late segments never wrap.
      function lerp_result_type interpolate_at(logic [31:0] t);
         lerp_result_type res;
         longint acc, a, b, span, off, t64;
         int cnt, idx;
         res = '0;
         t64 = longint'({32'd0, t});
         cnt = (seg_count > SEG_LIMIT) ? SEG_LIMIT : int'(seg_count);
         if (t <= start_time || cnt == 0) begin
            res.value = keys[0];
            n_early++;
            return res;
         end
         acc = longint'({32'd0, start_time});
         idx = 0;
         while (idx < cnt && t64 > acc + longint'({48'd0, durs[idx]})) begin
            acc += longint'({48'd0, durs[idx]});
            idx++;
         end
         if (idx == cnt) begin
            res.value    = keys[cnt];
            res.segment  = 3'(cnt);
            res.past_end = 1'b1;
            n_past++;
         end else begin
            a = keys[idx];
            res.segment = 3'(idx);
            if (interp) begin
               b    = keys[idx + 1];
               span = longint'({48'd0, durs[idx]});
               off  = t64 - acc;
               res.value = 16'(a + ((b - a) * off) / span);
            end else begin
               res.value = 16'(a);
            end
            n_inside++;
         end
         return res;
      endfunction

      function void note_input(key_beat_type beat);
         case (beat.op)
            OP_KEY: begin
               if (beat.slot <= SEG_LIMIT) keys[beat.slot] = beat.key_value;
            end
            OP_DURATION: begin
               if (beat.slot < SEG_LIMIT) durs[beat.slot] = beat.duration;
            end
            OP_QUERY: begin
               awaited_values.push_back(interpolate_at(beat.query_time));
               n_queries++;
            end
            default: ;
         endcase
      endfunction

      task report_mismatch(string what, int want, int got);
         mismatches++;
         if (mismatches <= 30)
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
      endtask

      task check_result(lerp_result_type got);
         lerp_result_type want;
         if (awaited_values.size() == 0) begin
            report_mismatch("unexpected result beat", 0, int'(got.value));
            return;
         end
         want = awaited_values.pop_front();
         n_checked++;
         if (got.value !== want.value)
            report_mismatch("value", int'(want.value), int'(got.value));
         if (got.segment !== want.segment)
            report_mismatch("segment", int'(want.segment), int'(got.segment));
         if (got.past_end !== want.past_end)
            report_mismatch("past_end", int'(want.past_end), int'(got.past_end));
      endtask
   endclass

   logic clock;
   logic reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic        csr_pready;

   klerp_req_if req_ch ();
   klerp_rsp_if rsp_ch ();

   keyframe_piecewise_lerp_unit #(
      .MAX_SEGMENTS(SEG_LIMIT),
      .VALUE_BITS  (16)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   keyframe_checker sb;
   bit req_calm;
   bit rsp_calm;
   int n_beats;
   int n_ignored;
   int n_settings;
   int cycle_count;

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap(bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic key_beat_type make_beat(op_code_type op, logic [2:0] slot,
                                              logic [15:0] kv, logic [15:0] dur,
                                              logic [31:0] t);
      key_beat_type beat;
      beat.op         = op;
      beat.slot       = slot;
      beat.key_value  = kv;
      beat.duration   = dur;
      beat.query_time = t;
      return beat;
   endfunction

   // valid stays high across back-to-back beats; it is lowered only for a gap or while settling.
   task automatic send_beat(key_beat_type beat);
      int gap;
      if ($urandom_range(0, 149) == 0) req_calm = !req_calm;
      gap = pick_gap(req_calm);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.op         <= beat.op;
      req_ch.slot       <= beat.slot;
      req_ch.key_value  <= beat.key_value;
      req_ch.duration   <= beat.duration;
      req_ch.query_time <= beat.query_time;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_input(beat);
      n_beats++;
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(logic [31:0] start, logic [2:0] count, logic interp_on);
      reg_idx_type regs [3];
      logic [31:0] vals [3];
      regs = '{REG_START_TIME, REG_SEGMENT_COUNT, REG_INTERPOLATE};
      vals = '{start, {29'd0, count}, {31'd0, interp_on}};
      for (int r = 0; r < 3; r++) begin
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b1;
         csr_paddr   <= {regs[r], 2'b00};
         csr_pwdata  <= vals[r];
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         sb.set_register(regs[r], vals[r]);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      n_settings++;
   endtask

   initial begin
      int stall;
      stall = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_ch.valid && rsp_ch.ready)
               sb.check_result({rsp_ch.value, rsp_ch.segment, rsp_ch.past_end});
            if ($urandom_range(0, 299) == 0) rsp_calm = !rsp_calm;
            if (stall > 0) begin
               stall--;
               rsp_ch.ready <= 1'b0;
            end else begin
               stall = pick_gap(rsp_calm);
               rsp_ch.ready <= (stall == 0);
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, sb.outstanding());
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      key_beat_type beat;
      logic [15:0]  corner_keys [6];
      logic [15:0]  corner_durs [5];
      logic [31:0]  early_times [8];
      logic [31:0]  st, bound, span;
      logic [2:0]   count_v;
      logic         interp_v;
      int           done, kind, cnt, k;

      sb = new();
      req_calm   = 1'b0;
      rsp_calm   = 1'b0;
      n_beats    = 0;
      n_ignored  = 0;
      n_settings = 0;
      corner_keys = '{16'h8000, 16'h7FFF, 16'h0100, 16'hFF00, 16'h1234, 16'hC000};
      corner_durs = '{16'd10, 16'd0, 16'hFFFF, 16'd3, 16'd1};
      // Start, inside and at the ends of segments, the skipped empty segment, past the end.
      early_times = '{32'd100, 32'd101, 32'd110, 32'd111, 32'd65645, 32'd65649,
                      32'd65650, 32'hFFFF_FFFF};

      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.op         <= OP_QUERY;
      req_ch.slot       <= '0;
      req_ch.key_value  <= '0;
      req_ch.duration   <= '0;
      req_ch.query_time <= '0;
      csr_psel          <= 1'b0;
      csr_penable       <= 1'b0;
      csr_pwrite        <= 1'b0;
      csr_paddr         <= '0;
      csr_pwdata        <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // With no segments in use every query returns key 0.
      send_beat(make_beat(OP_QUERY, 3'd0, 16'd0, 16'd0, 32'd0));
      send_beat(make_beat(OP_QUERY, 3'd0, 16'd0, 16'd0, 32'hFFFF_FFFF));
      for (int i = 0; i < 6; i++)
         send_beat(make_beat(OP_KEY, 3'(i), corner_keys[i], 16'd0, 32'd0));
      send_beat(make_beat(OP_KEY, 3'd6, 16'h5555, 16'd0, 32'd0));
      for (int i = 0; i < 5; i++)
         send_beat(make_beat(OP_DURATION, 3'(i), 16'd0, corner_durs[i], 32'd0));
      send_beat(make_beat(OP_DURATION, 3'd5, 16'd0, 16'hFFFF, 32'd0));
      send_beat(make_beat(OP_RESERVED, 3'd0, 16'h7777, 16'h7777, 32'd50));
      send_beat(make_beat(OP_QUERY, 3'd0, 16'd0, 16'd0, 32'd5));

      settle();
      configure(32'd100, 3'd5, 1'b1);
      foreach (early_times[i])
         send_beat(make_beat(OP_QUERY, 3'd0, 16'd0, 16'd0, early_times[i]));

      // A count above the number of segments is held at five; hold mode.
      settle();
      configure(32'd100, 3'd7, 1'b0);
      send_beat(make_beat(OP_QUERY, 3'd0, 16'd0, 16'd0, 32'd111));
      send_beat(make_beat(OP_QUERY, 3'd0, 16'd0, 16'd0, 32'd65650));

      settle();
      configure(32'hFFFF_FFFF, 3'd5, 1'b1);
      send_beat(make_beat(OP_QUERY, 3'd0, 16'd0, 16'd0, 32'hFFFF_FFFF));

      // Segment ends beyond the 32-bit time range.
      settle();
      configure(32'hFFFF_0000, 3'd5, 1'b1);
      send_beat(make_beat(OP_QUERY, 3'd0, 16'd0, 16'd0, 32'hFFFF_FFFF));

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         case ($urandom_range(0, 5))
            0:       st = 32'd0;
            1:       st = 32'hFFFF_FFFF;
            2:       st = 32'hFFFF_FFFF - $urandom_range(0, 200000);
            3:       st = $urandom;
            default: st = $urandom_range(0, 1000);
         endcase
         count_v  = $urandom_range(0, 1) ? 3'd5 : 3'($urandom_range(0, 7));
         interp_v = 1'($urandom_range(0, 1));
         if (phase == 0) begin
            st = 32'd0;
            count_v = 3'd7;
            interp_v = 1'b1;
         end else if (phase == 1) begin
            st = 32'hFFFF_FFFF;
            count_v = 3'd0;
            interp_v = 1'b0;
         end
         configure(st, count_v, interp_v);
         req_calm = ($urandom_range(0, 3) == 0);

         done = 0;
         while (done < PHASE_ITEMS) begin
            beat.slot       = 3'($urandom_range(0, 7));
            beat.key_value  = 16'($urandom);
            beat.duration   = 16'($urandom);
            beat.query_time = $urandom;
            kind = $urandom_range(0, 99);
            if (kind < 10) begin
               // Beats that the block must drop without a trace.
               case ($urandom_range(0, 2))
                  0: beat.op = OP_RESERVED;
                  1: begin
                     beat.op   = OP_KEY;
                     beat.slot = 3'($urandom_range(6, 7));
                  end
                  default: begin
                     beat.op   = OP_DURATION;
                     beat.slot = 3'($urandom_range(5, 7));
                  end
               endcase
               n_ignored++;
            end else if (kind < 30) begin
               beat.op   = OP_KEY;
               beat.slot = 3'($urandom_range(0, 5));
               case ($urandom_range(0, 7))
                  0: beat.key_value = 16'h8000;
                  1: beat.key_value = 16'h7FFF;
                  default: ;
               endcase
               done++;
            end else if (kind < 50) begin
               beat.op   = OP_DURATION;
               beat.slot = 3'($urandom_range(0, 4));
               case ($urandom_range(0, 7))
                  0:       beat.duration = 16'd0;
                  1:       beat.duration = 16'hFFFF;
                  2, 3:    ;
                  default: beat.duration = 16'($urandom_range(1, 40));
               endcase
               done++;
            end else begin
               beat.op = OP_QUERY;
               cnt = (sb.seg_count > SEG_LIMIT) ? SEG_LIMIT : int'(sb.seg_count);
               span = 32'd0;
               for (int i = 0; i < cnt; i++) span += 32'(sb.durs[i]);
               case ($urandom_range(0, 7))
                  0: ;
                  1: beat.query_time = sb.start_time - $urandom_range(0, 2);
                  2: begin
                     k = $urandom_range(0, cnt);
                     bound = sb.start_time;
                     for (int i = 0; i < k; i++) bound += 32'(sb.durs[i]);
                     beat.query_time = bound + $urandom_range(0, 1);
                  end
                  default: beat.query_time = sb.start_time + 1 + $urandom_range(0, span + 3);
               endcase
               done++;
            end
            send_beat(beat);
         end
      end

      settle();
      $display("Drove %0d input beats (%0d queries, %0d dropped) under %0d register settings.",
               n_beats, sb.n_queries, n_ignored, n_settings);
      $display("Checked %0d results: %0d early or empty, %0d within a segment, %0d past the end.",
               sb.n_checked, sb.n_early, sb.n_inside, sb.n_past);
      if (sb.mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
